@@ rtl/slce_pkg.sv @@
// Shared types, constants and helpers for the SLCAN line encoder.
package slce_pkg;

  localparam int unsigned ID_W        = 29;
  localparam int unsigned DLC_W       = 4;
  localparam int unsigned PAYLOAD_W   = 64;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned TERM_W      = 4;
  localparam int unsigned ID_ALIGN_W  = 32;
  localparam int unsigned NIB_CNT_W   = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_BYTES   = 8;

  localparam logic [TERM_W-1:0] TERM_RESET = 4'd13;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_EXT_D = 8'h54;  // 'T'
  localparam logic [CHAR_W-1:0] CHAR_EXT_R = 8'h52;  // 'R'
  localparam logic [CHAR_W-1:0] CHAR_STD_D = 8'h74;  // 't'
  localparam logic [CHAR_W-1:0] CHAR_STD_R = 8'h72;  // 'r'

  localparam logic [2:0] ID_LAST_EXT = 3'd7;
  localparam logic [2:0] ID_LAST_STD = 3'd2;

  // One classified frame, ready for the character sequencer.
  typedef struct packed {
    logic [CHAR_W-1:0]     letter;
    logic [ID_ALIGN_W-1:0] id_aligned;  // first digit in the top nibble
    logic [2:0]            id_last;     // number of identifier digits minus one
    logic [DLC_W-1:0]      dlc;
    logic [NIB_CNT_W-1:0]  data_nibs;   // payload digits to print
    logic [PAYLOAD_W-1:0]  payload;
  } frame_desc_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    logic [CHAR_W-1:0] ext_v;
    ext_v = {4'b0000, v};
    if (v > 4'd9) begin
      hex_char = ext_v - 8'd10 + CHAR_A;
    end else begin
      hex_char = ext_v + CHAR_ZERO;
    end
  endfunction

endpackage

@@ rtl/slce_front.sv @@
// Front end: takes frames in and classifies them into line descriptors.
module slce_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          is_extended_i,
  input  logic                          is_remote_i,
  input  logic [slce_pkg::ID_W-1:0]     identifier_i,
  input  logic [slce_pkg::DLC_W-1:0]    length_code_i,
  input  logic [slce_pkg::PAYLOAD_W-1:0] payload_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output slce_pkg::frame_desc_t         q_desc_o
);
  import slce_pkg::*;

  logic [DLC_W-1:0] n_bytes;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Long length codes still print only eight payload bytes.
  assign n_bytes = (length_code_i > DLC_W'(MAX_BYTES)) ? DLC_W'(MAX_BYTES) : length_code_i;

  always_comb begin
    q_desc_o = '0;
    if (is_extended_i) begin
      q_desc_o.letter     = is_remote_i ? CHAR_EXT_R : CHAR_EXT_D;
      q_desc_o.id_aligned = {3'b000, identifier_i};
      q_desc_o.id_last    = ID_LAST_EXT;
    end else begin
      q_desc_o.letter     = is_remote_i ? CHAR_STD_R : CHAR_STD_D;
      q_desc_o.id_aligned = {identifier_i[11:0], 20'h00000};
      q_desc_o.id_last    = ID_LAST_STD;
    end
    q_desc_o.dlc       = length_code_i;
    q_desc_o.data_nibs = is_remote_i ? '0 : {n_bytes, 1'b0};
    q_desc_o.payload   = payload_i;
  end

endmodule

@@ rtl/slce_queue.sv @@
// Small register queue of frame descriptors between front and back.
module slce_queue #(
  parameter int unsigned Depth = slce_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  slce_pkg::frame_desc_t push_desc_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output slce_pkg::frame_desc_t head_desc_o
);
  import slce_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_desc_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_desc_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

@@ rtl/slce_back.sv @@
// Back end: walks one descriptor and emits its line one character at a time.
module slce_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [slce_pkg::TERM_W-1:0] term_i,
  input  logic                        head_valid_i,
  input  slce_pkg::frame_desc_t       head_desc_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [slce_pkg::CHAR_W-1:0] character_o,
  output logic                        last_o
);
  import slce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ID   = 5'b00010,
    S_DLC  = 5'b00100,
    S_DATA = 5'b01000,
    S_TERM = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [ID_ALIGN_W-1:0]   id_q, id_d;
  logic [PAYLOAD_W-1:0]    pay_q, pay_d;
  logic [DLC_W-1:0]        dlc_q, dlc_d;
  logic [NIB_CNT_W-1:0]    nibs_q, nibs_d;
  logic [NIB_CNT_W-1:0]    cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]       char_q, char_d;
  logic                    last_q, last_d;
  logic                    advance;
  logic                    emit;

  // The output register may take a new character when it is empty or drained.
  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && ((state_q != S_IDLE) || head_valid_i);
  assign pop_o   = advance && (state_q == S_IDLE) && head_valid_i;

  always_comb begin
    state_d     = state_q;
    id_d        = id_q;
    pay_d       = pay_q;
    dlc_d       = dlc_q;
    nibs_d      = nibs_q;
    cnt_d       = cnt_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = advance ? emit : out_valid_q;
    if (emit) begin
      last_d = 1'b0;
      case (state_q)
        S_IDLE: begin
          char_d  = head_desc_i.letter;
          id_d    = head_desc_i.id_aligned;
          pay_d   = head_desc_i.payload;
          dlc_d   = head_desc_i.dlc;
          nibs_d  = head_desc_i.data_nibs;
          cnt_d   = NIB_CNT_W'(head_desc_i.id_last);
          state_d = S_ID;
        end
        S_ID: begin
          char_d = hex_char(id_q[ID_ALIGN_W-1 -: 4]);
          id_d   = {id_q[ID_ALIGN_W-5:0], 4'h0};
          cnt_d  = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_d = S_DLC;
          end
        end
        S_DLC: begin
          char_d = hex_char(dlc_q);
          cnt_d  = nibs_q - 1'b1;
          state_d = (nibs_q == '0) ? S_TERM : S_DATA;
        end
        S_DATA: begin
          // Odd count gives the high nibble of the current byte, even the low one.
          if (cnt_q[0]) begin
            char_d = hex_char(pay_q[7:4]);
          end else begin
            char_d = hex_char(pay_q[3:0]);
            pay_d  = {8'h00, pay_q[PAYLOAD_W-1:8]};
          end
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_d = S_TERM;
          end
        end
        S_TERM: begin
          char_d  = {4'h0, term_i};
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    pay_q  <= pay_d;
    dlc_q  <= dlc_d;
    nibs_q <= nibs_d;
    cnt_q  <= cnt_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

@@ rtl/slcan_ascii_frame_encoder_unit.sv @@
// Top level of the SLCAN line encoder: CAN frame in, ASCII characters out.
//
//   Channel  Direction  Handshake                 Payload
//   frame    in         in_valid_i / in_stall_o   is_extended_i is_remote_i identifier_i
//                                                 length_code_i payload_i
//   chars    out        out_valid_o / out_stall_i character_o last_o
//   config   in         cfg_we_i                  cfg_wdata_i (line terminator)
//
// Each frame yields 6 to 27 characters, one per cycle unless out_stall_i holds the
// output, set by the character sequencer in the back end. Frames queue in a small
// descriptor queue so the front keeps accepting while a line is still being sent.
// A frame's first character passes the descriptor queue, then the back end's output
// register. Reset clears the queue and sequencer and sets the terminator to carriage
// return. A stalled output holds its character and pauses the line.
module slcan_ascii_frame_encoder_unit #(
  parameter int unsigned QueueDepth = slce_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [slce_pkg::TERM_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           is_extended_i,
  input  logic                           is_remote_i,
  input  logic [slce_pkg::ID_W-1:0]      identifier_i,
  input  logic [slce_pkg::DLC_W-1:0]     length_code_i,
  input  logic [slce_pkg::PAYLOAD_W-1:0] payload_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [slce_pkg::CHAR_W-1:0]    character_o,
  output logic                           last_o
);
  import slce_pkg::*;

  logic [TERM_W-1:0] term_q;
  logic              q_full, q_push, q_pop, q_head_valid;
  frame_desc_t       q_push_desc, q_head_desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= TERM_RESET;
    end else if (cfg_we_i) begin
      term_q <= cfg_wdata_i;
    end
  end

  slce_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .is_extended_i (is_extended_i),
    .is_remote_i   (is_remote_i),
    .identifier_i  (identifier_i),
    .length_code_i (length_code_i),
    .payload_i     (payload_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_desc_o      (q_push_desc)
  );

  slce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_desc_i  (q_push_desc),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_desc_o  (q_head_desc)
  );

  slce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_i       (term_q),
    .head_valid_i (q_head_valid),
    .head_desc_i  (q_head_desc),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .character_o  (character_o),
    .last_o       (last_o)
  );

endmodule
